// File: rtl/core/itrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itrd_pkg;

  // Field and register widths
  localparam int unsigned NumWidth    = 32;
  localparam int unsigned CharWidth   = 8;
  localparam int unsigned AlphaWidth  = 64;
  localparam int unsigned LenWidth    = 5;
  localparam int unsigned CfgIdxWidth = 2;

  // Alphabet and digit store geometry
  localparam int unsigned NumChars    = 16;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned MaxDigits   = 32;
  localparam int unsigned DigCntWidth = 6;
  localparam int unsigned ByteIdxWidth = 2;

  // Defaults for top-level parameters
  localparam int unsigned MaxRadixDefault = 16;
  localparam int unsigned QueueDepth      = 2;

  // Character codes
  localparam logic [CharWidth-1:0] CharPlus  = 8'd43;
  localparam logic [CharWidth-1:0] CharMinus = 8'd45;
  localparam logic [CharWidth-1:0] CharNul   = 8'd0;
  localparam logic [LenWidth-1:0]  MinRadix  = 5'd2;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgDigitsLow  = 2'd0,
    CfgDigitsHigh = 2'd1,
    CfgRadixLen   = 2'd2
  } cfg_idx_e;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    BkIdle   = 4'b0001,
    BkDivide = 4'b0010,
    BkSign   = 4'b0100,
    BkEmit   = 4'b1000
  } back_state_e;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic                bad;
    logic                neg;
    logic [LenWidth-1:0] radix;
    logic [NumWidth-1:0] mag;
  } job_t;

  // Pick digit character k out of the two packed alphabet words
  function automatic logic [CharWidth-1:0] alpha_char(
    input logic [AlphaWidth-1:0] lo,
    input logic [AlphaWidth-1:0] hi,
    input logic [DigitWidth-1:0] k
  );
    logic [AlphaWidth-1:0] word;
    word = k[3] ? hi : lo;
    return word[{k[2:0], 3'b000} +: CharWidth];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/itrd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module itrd_front #(
  parameter int unsigned MaxRadix = itrd_pkg::MaxRadixDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  input  logic signed [itrd_pkg::NumWidth-1:0]  number_i,
  input  logic [itrd_pkg::AlphaWidth-1:0]       digits_lo_i,
  input  logic [itrd_pkg::AlphaWidth-1:0]       digits_hi_i,
  input  logic [itrd_pkg::LenWidth-1:0]         radix_len_i,
  input  logic                                  q_full_i,
  output logic                                  q_push_o,
  output itrd_pkg::job_t                        q_job_o,
  output logic                                  busy
);
  import itrd_pkg::*;

  logic                front_valid_q, front_valid_d;
  logic [NumWidth-1:0] num_q;
  logic                accept;
  logic                alpha_bad;
  logic                neg;
  logic [CharWidth-1:0] chars [NumChars];

  // Hold off new items while one waits here or the queue is full
  assign busy     = front_valid_q | q_full_i;
  assign accept   = start & ~busy;
  assign q_push_o = front_valid_q & ~q_full_i;

  always_comb begin
    front_valid_d = front_valid_q;
    if (accept) begin
      front_valid_d = 1'b1;
    end else if (q_push_o) begin
      front_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else begin
      front_valid_q <= front_valid_d;
    end
  end

  // Capture the number
  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q <= $unsigned(number_i);
    end
  end

  // Check the alphabet: length, forbidden characters, repeats
  always_comb begin
    alpha_bad = 1'b0;
    for (int i = 0; i < NumChars; i++) begin
      chars[i] = alpha_char(digits_lo_i, digits_hi_i, DigitWidth'(i));
    end
    for (int i = 0; i < NumChars; i++) begin
      if (LenWidth'(i) < radix_len_i) begin
        if (chars[i] == CharNul || chars[i] == CharPlus || chars[i] == CharMinus) begin
          alpha_bad = 1'b1;
        end
        for (int j = i + 1; j < NumChars; j++) begin
          if (LenWidth'(j) < radix_len_i && chars[j] == chars[i]) begin
            alpha_bad = 1'b1;
          end
        end
      end
    end
    if (radix_len_i < MinRadix || radix_len_i > LenWidth'(MaxRadix)) begin
      alpha_bad = 1'b1;
    end
  end

  // Split into sign and unsigned magnitude
  assign neg           = num_q[NumWidth-1];
  assign q_job_o.bad   = alpha_bad;
  assign q_job_o.neg   = neg;
  assign q_job_o.radix = radix_len_i;
  assign q_job_o.mag   = neg ? (NumWidth'(0) - num_q) : num_q;

endmodule

`default_nettype wire

// File: rtl/core/itrd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module itrd_queue #(
  parameter int unsigned Depth = itrd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  itrd_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output itrd_pkg::job_t pop_job_o,
  output logic           empty_o
);
  import itrd_pkg::*;

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  job_t                mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;

  assign full_o    = (count_q == CntWidth'(Depth));
  assign empty_o   = (count_q == '0);
  assign pop_job_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntWidth'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/itrd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module itrd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  itrd_pkg::job_t                    q_job_i,
  output logic                              q_pop_o,
  input  logic [itrd_pkg::AlphaWidth-1:0]   digits_lo_i,
  input  logic [itrd_pkg::AlphaWidth-1:0]   digits_hi_i,
  output logic                              out_valid_o,
  output logic [itrd_pkg::CharWidth-1:0]    out_char_o,
  output logic                              is_last_o,
  output logic                              bad_alphabet_o
);
  import itrd_pkg::*;

  back_state_e             state_q, state_d;
  logic [DigCntWidth-1:0]  cnt_q, cnt_d;
  logic [ByteIdxWidth-1:0] byte_q, byte_d;
  logic                    neg_q, neg_d;
  logic [LenWidth-1:0]     radix_q, radix_d;
  logic [NumWidth-1:0]     quo_q, quo_d;
  logic [DigitWidth-1:0]   rem_q, rem_d;
  logic [DigitWidth-1:0]   digits_q [MaxDigits];
  logic                    dig_we;
  logic                    valid_q, valid_d;
  logic [CharWidth-1:0]    char_q, char_d;
  logic                    last_q, last_d;
  logic                    bad_q, bad_d;

  logic [CharWidth-1:0]    cur_byte;
  logic [CharWidth-1:0]    step_quo;
  logic [DigitWidth-1:0]   step_rem;
  logic [LenWidth-1:0]     part;
  logic [NumWidth-1:0]     quo_step;
  logic [DigCntWidth-1:0]  cnt_m1;

  // Highest byte of a word that holds a set bit
  function automatic logic [ByteIdxWidth-1:0] top_byte(input logic [NumWidth-1:0] x);
    if (x[31:24] != '0) begin
      return 2'd3;
    end else if (x[23:16] != '0) begin
      return 2'd2;
    end else if (x[15:8] != '0) begin
      return 2'd1;
    end
    return 2'd0;
  endfunction

  // Restoring division, eight quotient bits per cycle
  assign cur_byte = quo_q[{byte_q, 3'b000} +: CharWidth];

  always_comb begin
    part     = '0;
    step_rem = rem_q;
    step_quo = '0;
    for (int k = CharWidth - 1; k >= 0; k--) begin
      part = {step_rem, cur_byte[k]};
      if (part >= radix_q) begin
        step_quo[k] = 1'b1;
        part        = part - radix_q;
      end
      step_rem = part[DigitWidth-1:0];
    end
  end

  always_comb begin
    quo_step = quo_q;
    quo_step[{byte_q, 3'b000} +: CharWidth] = step_quo;
  end

  assign cnt_m1 = cnt_q - DigCntWidth'(1);

  // Sequence: take item, peel digits, emit sign (if negative) then digits; a bad alphabet gives one blank result
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    byte_d  = byte_q;
    neg_d   = neg_q;
    radix_d = radix_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dig_we  = 1'b0;
    valid_d = 1'b0;
    char_d  = char_q;
    last_d  = last_q;
    bad_d   = bad_q;
    q_pop_o = 1'b0;
    case (state_q)
      BkIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_job_i.bad) begin
            valid_d = 1'b1;
            char_d  = CharNul;
            last_d  = 1'b1;
            bad_d   = 1'b1;
          end else begin
            neg_d   = q_job_i.neg;
            radix_d = q_job_i.radix;
            quo_d   = q_job_i.mag;
            rem_d   = '0;
            byte_d  = top_byte(q_job_i.mag);
            cnt_d   = '0;
            state_d = BkDivide;
          end
        end
      end
      BkDivide: begin
        quo_d = quo_step;
        rem_d = step_rem;
        if (byte_q != '0) begin
          byte_d = byte_q - ByteIdxWidth'(1);
        end else begin
          dig_we = 1'b1;
          cnt_d  = cnt_q + DigCntWidth'(1);
          rem_d  = '0;
          if (quo_step == '0 || cnt_q == DigCntWidth'(MaxDigits - 1)) begin
            state_d = neg_q ? BkSign : BkEmit;
          end else begin
            byte_d = top_byte(quo_step);
          end
        end
      end
      BkSign: begin
        valid_d = 1'b1;
        char_d  = CharMinus;
        last_d  = 1'b0;
        bad_d   = 1'b0;
        state_d = BkEmit;
      end
      BkEmit: begin
        valid_d = 1'b1;
        char_d  = alpha_char(digits_lo_i, digits_hi_i, digits_q[cnt_m1[4:0]]);
        last_d  = (cnt_q == DigCntWidth'(1));
        bad_d   = 1'b0;
        cnt_d   = cnt_m1;
        if (cnt_q == DigCntWidth'(1)) begin
          state_d = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      cnt_q   <= '0;
      byte_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      byte_q  <= byte_d;
      valid_q <= valid_d;
    end
  end

  // Hold working values and the result
  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    radix_q <= radix_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    char_q  <= char_d;
    last_q  <= last_d;
    bad_q   <= bad_d;
    if (dig_we) begin
      digits_q[cnt_q[4:0]] <= step_rem;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_char_o     = char_q;
  assign is_last_o      = last_q;
  assign bad_alphabet_o = bad_q;

  // An alphabet error is a lone, final, blank character
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && bad_q |-> last_q && (char_q == CharNul))
    else $error("alphabet error result not final or not blank");

  // Emission never runs with an empty digit store
  a_emit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkEmit) |-> (cnt_q != '0))
    else $error("emitting with no digits left");

  // Partial remainder stays below the radix
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkDivide) |-> ({1'b0, rem_q} < radix_q) && (radix_q >= MinRadix))
    else $error("partial remainder out of range");

endmodule

`default_nettype wire

// File: rtl/core/integer_to_radix_digits.sv
// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+--------------------------
// input    | number_i                                     | start high, busy low
// result   | out_char_o, is_last_o, bad_alphabet_o        | out_valid_o, one cycle
// config   | cfg_index_i, cfg_data_i                      | cfg_we_i, no wait
//
// The front registers an item and classifies it (alphabet check, sign and magnitude)
// combinationally, then pushes it into a two-entry queue.
// The back peels digits with a shared 8-bit restoring divider that works through the
// significant bytes of the remaining quotient for each digit, then emits the sign (for a
// negative number) and one character per digit. Worst case is the most negative
// number in radix 2. An alphabet error gives its single result in the cycle after the
// item leaves the queue.
// Reset clears the configuration registers, the queue and both sequencers.
// The receiver cannot stall; busy stays high while the front holds an item or the
// queue is full.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_digits #(
  parameter int unsigned MaxRadix = itrd_pkg::MaxRadixDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [itrd_pkg::NumWidth-1:0] number_i,
  input  logic                                 cfg_we_i,
  input  logic [itrd_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [itrd_pkg::AlphaWidth-1:0]      cfg_data_i,
  output logic                                 out_valid_o,
  output logic [itrd_pkg::CharWidth-1:0]       out_char_o,
  output logic                                 is_last_o,
  output logic                                 bad_alphabet_o
);
  import itrd_pkg::*;

  logic [AlphaWidth-1:0] digits_lo_q;
  logic [AlphaWidth-1:0] digits_hi_q;
  logic [LenWidth-1:0]   radix_len_q;

  logic q_push, q_pop, q_full, q_empty;
  job_t push_job, pop_job;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_lo_q <= '0;
      digits_hi_q <= '0;
      radix_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgDigitsLow:  digits_lo_q <= cfg_data_i;
        CfgDigitsHigh: digits_hi_q <= cfg_data_i;
        CfgRadixLen:   radix_len_q <= cfg_data_i[LenWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  itrd_front #(
    .MaxRadix (MaxRadix)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .number_i    (number_i),
    .digits_lo_i (digits_lo_q),
    .digits_hi_i (digits_hi_q),
    .radix_len_i (radix_len_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (push_job),
    .busy        (busy)
  );

  itrd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_job_o  (pop_job),
    .empty_o    (q_empty)
  );

  itrd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_job_i        (pop_job),
    .q_pop_o        (q_pop),
    .digits_lo_i    (digits_lo_q),
    .digits_hi_i    (digits_hi_q),
    .out_valid_o    (out_valid_o),
    .out_char_o     (out_char_o),
    .is_last_o      (is_last_o),
    .bad_alphabet_o (bad_alphabet_o)
  );

endmodule

`default_nettype wire
